@@ hw/rtl/rbe_pkg.sv @@
// rbe_pkg: shared constants, status codes and configuration type for the
// root bracket expander. No dependencies.

package rbe_pkg;

  localparam int DATA_WIDTH_DEF = 32;

  localparam int FACTOR_W    = 16;
  localparam int FACTOR_FRAC = 8;
  localparam int LIMIT_W     = 8;
  localparam int STATUS_W    = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [FACTOR_W-1:0] FACTOR_RST = FACTOR_W'(410);
  localparam logic [LIMIT_W-1:0]  LIMIT_RST  = LIMIT_W'(50);

  localparam logic [CFG_IDX_W-1:0] REG_EXPAND_FACTOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TRY_LIMIT     = 1'b1;

  localparam logic [STATUS_W-1:0] ST_EVAL       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BRACKETED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FAILED     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_INVALID    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNEXPECTED = 3'd4;

  typedef struct packed {
    logic [FACTOR_W-1:0] expand_factor;
    logic [LIMIT_W-1:0]  try_limit;
  } cfg_t;

endpackage

@@ hw/rtl/rbe_expand.sv @@
// rbe_expand: moving + round(factor * (moving - other)), saturated.
// Depends on rbe_pkg for the factor format.

module rbe_expand #(
  parameter int DW = rbe_pkg::DATA_WIDTH_DEF
) (
  input  logic signed [DW-1:0]                moving,
  input  logic signed [DW-1:0]                other,
  input  logic        [rbe_pkg::FACTOR_W-1:0] factor,
  output logic signed [DW-1:0]                result
);
  import rbe_pkg::*;

  localparam int PW = DW + 1 + FACTOR_W + 1;
  localparam int QW = PW - FACTOR_FRAC;
  localparam int SW = QW + 1;

  logic signed [DW:0]   diff;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] rnd;
  logic signed [QW-1:0] quo;
  logic signed [SW-1:0] sum;
  logic                 ovf;

  assign diff = (DW+1)'(moving) - (DW+1)'(other);
  assign prod = PW'(diff) * $signed(PW'({1'b0, factor}));
  // half-up rounding, ties toward plus infinity
  assign rnd  = prod + $signed(PW'(1) <<< (FACTOR_FRAC - 1));
  assign quo  = rnd[PW-1:FACTOR_FRAC];
  assign sum  = SW'(moving) + SW'(quo);
  assign ovf  = !((&sum[SW-1:DW-1]) || !(|sum[SW-1:DW-1]));

  always_comb begin
    if (!ovf) begin
      result = sum[DW-1:0];
    end else if (sum[SW-1]) begin
      result = {1'b1, {(DW-1){1'b0}}};
    end else begin
      result = {1'b0, {(DW-1){1'b1}}};
    end
  end

endmodule

@@ hw/rtl/rbe_core.sv @@
// rbe_core: bracketing state, per-request decision logic and result register.
// Depends on rbe_pkg and rbe_expand.

module rbe_core #(
  parameter int DW = rbe_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rbe_pkg::cfg_t                     cfg,
  input  logic                              item_vld,
  input  logic                              item_func,
  input  logic signed [DW-1:0]              item_a,
  input  logic signed [DW-1:0]              item_b,
  input  logic signed [DW-1:0]              item_value,
  output logic                              item_take,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic        [rbe_pkg::STATUS_W-1:0] out_status,
  output logic signed [DW-1:0]              out_eval_point,
  output logic signed [DW-1:0]              out_low_end,
  output logic signed [DW-1:0]              out_high_end
);
  import rbe_pkg::*;

  localparam logic [1:0] PH_IDLE       = 2'd0;
  localparam logic [1:0] PH_WAIT_A     = 2'd1;
  localparam logic [1:0] PH_WAIT_B     = 2'd2;
  localparam logic [1:0] PH_WAIT_MOVED = 2'd3;

  logic [1:0]           phase_r, phase_nxt;
  logic                 moved_r, moved_nxt;
  logic [LIMIT_W-1:0]   checks_r, checks_nxt;
  logic signed [DW-1:0] end_a_r, end_a_nxt;
  logic signed [DW-1:0] end_b_r, end_b_nxt;
  logic signed [DW-1:0] val_a_r, val_a_nxt;
  logic signed [DW-1:0] val_b_r, val_b_nxt;

  logic                 out_vld_r, out_vld_nxt;
  logic [STATUS_W-1:0]  out_status_r, res_status;
  logic signed [DW-1:0] out_point_r, res_point;
  logic signed [DW-1:0] out_low_r, res_low;
  logic signed [DW-1:0] out_high_r, res_high;

  logic signed [DW-1:0] va, vb;
  logic [DW-1:0]        mag_a, mag_b;
  logic                 move_a, strict;
  logic [LIMIT_W-1:0]   checks_inc, limit;
  logic signed [DW-1:0] grown_a, grown_b, new_end;
  logic signed [DW-1:0] a_after, b_after;

  assign item_take = item_vld && (!out_vld_r || !out_stall);

  // values seen by the sign check, including the one arriving now
  assign va = (phase_r == PH_WAIT_MOVED && !moved_r) ? item_value : val_a_r;
  assign vb = (phase_r == PH_WAIT_B || moved_r) ? item_value : val_b_r;

  assign mag_a  = va[DW-1] ? (~va + DW'(1)) : va;
  assign mag_b  = vb[DW-1] ? (~vb + DW'(1)) : vb;
  assign move_a = mag_a < mag_b;
  assign strict = (va[DW-1] && !vb[DW-1] && (|vb)) || (vb[DW-1] && !va[DW-1] && (|va));

  assign checks_inc = (&checks_r) ? checks_r : checks_r + LIMIT_W'(1);
  assign limit      = (cfg.try_limit < LIMIT_W'(2)) ? LIMIT_W'(1)
                                                    : cfg.try_limit - LIMIT_W'(1);

  // both candidate ends in parallel, the magnitude compare only selects
  rbe_expand #(.DW(DW)) u_expand_a (
    .moving (end_a_r),
    .other  (end_b_r),
    .factor (cfg.expand_factor),
    .result (grown_a)
  );

  rbe_expand #(.DW(DW)) u_expand_b (
    .moving (end_b_r),
    .other  (end_a_r),
    .factor (cfg.expand_factor),
    .result (grown_b)
  );

  assign new_end = move_a ? grown_a : grown_b;
  assign a_after = move_a ? grown_a : end_a_r;
  assign b_after = move_a ? end_b_r : grown_b;

  always_comb begin
    phase_nxt  = phase_r;
    moved_nxt  = moved_r;
    checks_nxt = checks_r;
    end_a_nxt  = end_a_r;
    end_b_nxt  = end_b_r;
    val_a_nxt  = val_a_r;
    val_b_nxt  = val_b_r;
    res_status = ST_EVAL;
    res_point  = '0;
    res_low    = '0;
    res_high   = '0;
    if (!item_func) begin
      if (item_a == item_b) begin
        phase_nxt  = PH_IDLE;
        res_status = ST_INVALID;
      end else begin
        end_a_nxt  = item_a;
        end_b_nxt  = item_b;
        val_a_nxt  = '0;
        val_b_nxt  = '0;
        moved_nxt  = 1'b0;
        checks_nxt = '0;
        phase_nxt  = PH_WAIT_A;
        res_point  = item_a;
      end
    end else begin
      unique case (phase_r) inside
        PH_WAIT_A: begin
          val_a_nxt = item_value;
          phase_nxt = PH_WAIT_B;
          res_point = end_b_r;
        end
        PH_WAIT_B, PH_WAIT_MOVED: begin
          val_a_nxt  = va;
          val_b_nxt  = vb;
          checks_nxt = checks_inc;
          if (strict) begin
            phase_nxt  = PH_IDLE;
            res_status = ST_BRACKETED;
            if (end_a_r > end_b_r) begin
              res_low  = end_b_r;
              res_high = end_a_r;
            end else begin
              res_low  = end_a_r;
              res_high = end_b_r;
            end
          end else begin
            end_a_nxt = a_after;
            end_b_nxt = b_after;
            moved_nxt = !move_a;
            if (checks_inc >= limit) begin
              phase_nxt  = PH_IDLE;
              res_status = ST_FAILED;
              res_low    = a_after;
              res_high   = b_after;
            end else begin
              phase_nxt = PH_WAIT_MOVED;
              res_point = new_end;
            end
          end
        end
        default: begin
          res_status = ST_UNEXPECTED;
        end
      endcase
    end
  end

  assign out_vld_nxt = item_take || (out_vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      moved_r   <= 1'b0;
      checks_r  <= '0;
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (item_take) begin
        phase_r  <= phase_nxt;
        moved_r  <= moved_nxt;
        checks_r <= checks_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      end_a_r      <= end_a_nxt;
      end_b_r      <= end_b_nxt;
      val_a_r      <= val_a_nxt;
      val_b_r      <= val_b_nxt;
      out_status_r <= res_status;
      out_point_r  <= res_point;
      out_low_r    <= res_low;
      out_high_r   <= res_high;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_status     = out_status_r;
  assign out_eval_point = out_point_r;
  assign out_low_end    = out_low_r;
  assign out_high_end   = out_high_r;

  a_moved_needs_check: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_WAIT_MOVED |-> checks_r != '0)
    else $error("moved-end phase without a completed check");

  a_take_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    item_take |=> out_vld_r)
    else $error("taken request produced no result");

  a_bracket_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_status_r == ST_BRACKETED |-> out_low_r <= out_high_r)
    else $error("bracket ends out of order");

  a_idle_value: assert property (@(posedge clk) disable iff (!rst_n)
    item_take && item_func && phase_r == PH_IDLE |=>
      out_status_r == ST_UNEXPECTED && $stable(phase_r))
    else $error("value while idle not flagged");

  a_equal_ends: assert property (@(posedge clk) disable iff (!rst_n)
    item_take && !item_func && item_a == item_b |=>
      out_status_r == ST_INVALID && phase_r == PH_IDLE)
    else $error("equal ends not rejected");

endmodule

@@ hw/rtl/root_bracket_expander.sv @@
// root_bracket_expander: top level with input register and configuration
// registers. Depends on rbe_pkg and rbe_core.
//
// Usage: a start request (in_func = 0) loads ends in_start_a/in_start_b; each
// result with status "evaluate" names out_eval_point, and the next value
// request (in_func = 1) returns f there in in_func_value. The run ends with
// status bracketed, failed, or invalid; a value request while idle gives
// status unexpected. Exactly one result per request, in order.
// Channels: in_valid/in_stall and out_valid/out_stall; a request moves on an
// edge with valid high and stall low. Configuration writes use cfg_valid/
// cfg_ready (always ready), cfg_index 0 = expand factor, 1 = try limit; the
// user makes them only while no request is in flight; nothing enforces it.
// A request passes the input register, then the decision and expansion
// logic into the result register.
// Throughput: one request per cycle while out_stall is low; the state update
// for one request is finished in the cycle that loads its result.
// Reset (rst_n low, synchronous): no run in progress, output empty, factor
// 1.6 and try limit 50. While out_stall is high the result holds, and one
// more request is held in the input register before in_stall rises.

module root_bracket_expander #(
  parameter int DATA_WIDTH = rbe_pkg::DATA_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [rbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [rbe_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_func,
  input  logic signed [DATA_WIDTH-1:0]          in_start_a,
  input  logic signed [DATA_WIDTH-1:0]          in_start_b,
  input  logic signed [DATA_WIDTH-1:0]          in_func_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic        [rbe_pkg::STATUS_W-1:0]   out_status,
  output logic signed [DATA_WIDTH-1:0]          out_eval_point,
  output logic signed [DATA_WIDTH-1:0]          out_low_end,
  output logic signed [DATA_WIDTH-1:0]          out_high_end
);
  import rbe_pkg::*;

  cfg_t                         cfg_r;
  logic                         in_vld_r, in_vld_nxt;
  logic                         func_r;
  logic signed [DATA_WIDTH-1:0] a_r, b_r, value_r;
  logic                         take;
  logic                         in_accept;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expand_factor <= FACTOR_RST;
      cfg_r.try_limit     <= LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_EXPAND_FACTOR: cfg_r.expand_factor <= cfg_data[FACTOR_W-1:0];
        REG_TRY_LIMIT:     cfg_r.try_limit     <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall   = in_vld_r && !take;
  assign in_accept  = in_valid && !in_stall;
  assign in_vld_nxt = in_accept || (in_vld_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      func_r  <= in_func;
      a_r     <= in_start_a;
      b_r     <= in_start_b;
      value_r <= in_func_value;
    end
  end

  rbe_core #(.DW(DATA_WIDTH)) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .item_vld       (in_vld_r),
    .item_func      (func_r),
    .item_a         (a_r),
    .item_b         (b_r),
    .item_value     (value_r),
    .item_take      (take),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_eval_point (out_eval_point),
    .out_low_end    (out_low_end),
    .out_high_end   (out_high_end)
  );

endmodule
